@@ hdl/pekf_pkg.sv @@
// Shared types, constants and microcode for the pressure elastic EKF unit.
package pekf_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned CfgW  = 31;
	localparam int unsigned IdxW  = 3;
	localparam int unsigned StepW = 6;

	localparam logic [IdxW-1:0] REG_MEAS_VAR = 3'd0;
	localparam logic [IdxW-1:0] REG_NOISE_P  = 3'd1;
	localparam logic [IdxW-1:0] REG_NOISE_K1 = 3'd2;
	localparam logic [IdxW-1:0] REG_NOISE_K2 = 3'd3;

	localparam logic [StepW-1:0] PRED_BASE = 6'd0;
	localparam logic [StepW-1:0] UPD_BASE  = 6'd32;

	localparam logic signed [DataW-1:0] ONE_Q  = 32'sd65536;
	localparam logic signed [DataW-1:0] MONE_Q = -32'sd65536;

	localparam logic [CfgW-1:0] MEAS_VAR_RST = 31'd65536;
	localparam logic [CfgW-1:0] NOISE_RST    = 31'd655;

	localparam logic FUNC_PREDICT = 1'b0;
	localparam logic FUNC_UPDATE  = 1'b1;

	typedef enum logic [5:0] {
		OP_ZERO, OP_ONE, OP_MONE, OP_P, OP_K1, OP_K2, OP_DX, OP_DT, OP_MEAS,
		OP_Q0, OP_Q1, OP_Q2, OP_T, OP_Y, OP_F0, OP_F1, OP_F2,
		OP_PF0, OP_PF1, OP_PF2,
		OP_C0, OP_C1, OP_C2, OP_C3, OP_C4, OP_C5, OP_C6, OP_C7, OP_C8,
		OP_O0, OP_O1, OP_O2, OP_O3, OP_O6
	} opnd_t;

	typedef struct packed {
		opnd_t a;
		opnd_t b;
		opnd_t add;
		opnd_t dst;
		logic  first;
		logic  last;
		logic  neg;
		logic  div;
		logic  fin;
	} ucmd_t;

	typedef struct packed {
		ucmd_t cmd;
		logic  load_in;
		logic  clr_sat;
		logic  set_sat;
		logic  snap;
		logic  mul_en;
		logic  acc_en;
		logic  div_start;
		logic  div_fin;
	} dp_ctrl_t;

	typedef struct packed {
		logic s_nonpos;
		logic div_busy;
	} dp_stat_t;

	function automatic ucmd_t mk(input opnd_t a, input opnd_t b, input opnd_t add,
			input opnd_t dst, input logic first, input logic last, input logic neg,
			input logic div, input logic fin);
		ucmd_t u;
		u.a = a; u.b = b; u.add = add; u.dst = dst;
		u.first = first; u.last = last; u.neg = neg; u.div = div; u.fin = fin;
		return u;
	endfunction

	function automatic ucmd_t ucode(input logic [StepW-1:0] step);
		ucmd_t u;
		case (step)
			6'd0:  u = mk(OP_P,  OP_DX,   OP_ZERO, OP_F2,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd1:  u = mk(OP_K2, OP_DX,   OP_ONE,  OP_F0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd2:  u = mk(OP_ZERO, OP_ZERO, OP_DX, OP_F1,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd3:  u = mk(OP_P,  OP_K2,   OP_K1,   OP_T,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd4:  u = mk(OP_T,  OP_DX,   OP_P,    OP_P,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd5:  u = mk(OP_C0, OP_F0,   OP_ZERO, OP_PF0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd6:  u = mk(OP_C1, OP_F1,   OP_ZERO, OP_PF0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd7:  u = mk(OP_C2, OP_F2,   OP_ZERO, OP_PF0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd8:  u = mk(OP_C3, OP_F0,   OP_ZERO, OP_PF1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd9:  u = mk(OP_C4, OP_F1,   OP_ZERO, OP_PF1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd10: u = mk(OP_C5, OP_F2,   OP_ZERO, OP_PF1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd11: u = mk(OP_C6, OP_F0,   OP_ZERO, OP_PF2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd12: u = mk(OP_C7, OP_F1,   OP_ZERO, OP_PF2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd13: u = mk(OP_C8, OP_F2,   OP_ZERO, OP_PF2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd14: u = mk(OP_F0, OP_C1,   OP_ZERO, OP_C1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd15: u = mk(OP_F1, OP_C4,   OP_ZERO, OP_C1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd16: u = mk(OP_F2, OP_C7,   OP_ZERO, OP_C1,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd17: u = mk(OP_F0, OP_C2,   OP_ZERO, OP_C2,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd18: u = mk(OP_F1, OP_C5,   OP_ZERO, OP_C2,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd19: u = mk(OP_F2, OP_C8,   OP_ZERO, OP_C2,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd20: u = mk(OP_F0, OP_PF0,  OP_ZERO, OP_C0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd21: u = mk(OP_F1, OP_PF1,  OP_ZERO, OP_C0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd22: u = mk(OP_F2, OP_PF2,  OP_ZERO, OP_C0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			6'd23: u = mk(OP_Q0, OP_DT,   OP_ZERO, OP_C0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd24: u = mk(OP_Q1, OP_DT,   OP_C4,   OP_C4,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd25: u = mk(OP_Q2, OP_DT,   OP_C8,   OP_C8,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd26: u = mk(OP_ZERO, OP_ZERO, OP_PF1, OP_C3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd27: u = mk(OP_ZERO, OP_ZERO, OP_PF2, OP_C6, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
			6'd32: u = mk(OP_P,  OP_MONE, OP_MEAS, OP_Y,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd33: u = mk(OP_O0, OP_Y,    OP_P,    OP_P,   1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
			6'd34: u = mk(OP_O3, OP_Y,    OP_K1,   OP_K1,  1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
			6'd35: u = mk(OP_O6, OP_Y,    OP_K2,   OP_K2,  1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
			6'd36: u = mk(OP_O0, OP_O0,   OP_C0,   OP_C0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
			6'd37: u = mk(OP_O0, OP_O1,   OP_C1,   OP_C1,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
			6'd38: u = mk(OP_O0, OP_O2,   OP_C2,   OP_C2,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
			6'd39: u = mk(OP_O3, OP_O0,   OP_C3,   OP_C3,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
			6'd40: u = mk(OP_O3, OP_O1,   OP_C4,   OP_C4,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
			6'd41: u = mk(OP_O3, OP_O2,   OP_C5,   OP_C5,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
			6'd42: u = mk(OP_O6, OP_O0,   OP_C6,   OP_C6,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
			6'd43: u = mk(OP_O6, OP_O1,   OP_C7,   OP_C7,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
			6'd44: u = mk(OP_O6, OP_O2,   OP_C8,   OP_C8,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
			default: u = mk(OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
		endcase
		return u;
	endfunction

endpackage

@@ hdl/pekf_ctrl.sv @@
// Sequencer that steps the microcode for predict and update beats.
module pekf_ctrl import pekf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     func,
	input  logic     out_busy,
	input  dp_stat_t stat,
	output logic     in_ready,
	output logic     load_out,
	output dp_ctrl_t ctrl
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_MUL   = 6'b000100,
		S_ACC   = 6'b001000,
		S_DIV   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [StepW-1:0]  step_q, step_d;
	ucmd_t             cmd;

	assign cmd      = ucode(step_q);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d        = state_q;
		step_d         = step_q;
		load_out       = 1'b0;
		ctrl           = '0;
		ctrl.cmd       = cmd;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load_in = 1'b1;
					ctrl.clr_sat = 1'b1;
					if (func == FUNC_UPDATE) begin
						step_d  = UPD_BASE;
						state_d = S_CHECK;
					end else begin
						step_d  = PRED_BASE;
						state_d = S_MUL;
					end
				end
			end
			S_CHECK: begin
				ctrl.snap = 1'b1;
				if (stat.s_nonpos) begin
					ctrl.set_sat = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				ctrl.mul_en = 1'b1;
				state_d     = S_ACC;
			end
			S_ACC: begin
				if (cmd.div) begin
					ctrl.div_start = 1'b1;
					state_d        = S_DIV;
				end else begin
					ctrl.acc_en = 1'b1;
					if (cmd.fin) begin
						state_d = S_DONE;
					end else begin
						step_d  = step_q + 6'd1;
						state_d = S_MUL;
					end
				end
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					ctrl.div_fin = 1'b1;
					if (cmd.fin) begin
						state_d = S_DONE;
					end else begin
						step_d  = step_q + 6'd1;
						state_d = S_MUL;
					end
				end
			end
			S_DONE: begin
				if (!out_busy) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

@@ hdl/pekf_dpath.sv @@
// Filter state, shared multiplier, accumulator and radix-2 divider.
module pekf_dpath import pekf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_ctrl_t                ctrl,
	input  logic                    cfg_we,
	input  logic [IdxW-1:0]         cfg_index,
	input  logic [CfgW-1:0]         cfg_data,
	input  logic signed [DataW-1:0] measured_pressure,
	input  logic [CfgW-1:0]         elapsed_time,
	input  logic signed [DataW-1:0] displacement_step,
	output dp_stat_t                stat,
	output logic signed [DataW-1:0] x0,
	output logic signed [DataW-1:0] x1,
	output logic signed [DataW-1:0] x2,
	output logic signed [DataW-1:0] c0,
	output logic                    sat
);

	logic [CfgW-1:0]         r_q, q0_q, q1_q, q2_q;
	logic signed [DataW-1:0] x_q [3];
	logic signed [DataW-1:0] c_q [9];
	logic signed [DataW-1:0] f_q [3];
	logic signed [DataW-1:0] pf_q [3];
	logic signed [DataW-1:0] o_q [5];
	logic signed [DataW-1:0] t_q, y_q, dx_q, meas_q;
	logic [CfgW-1:0]         dt_q;
	logic                    sat_q;

	logic signed [63:0]      prod_s1;
	logic signed [63:0]      acc_q;
	logic [31:0]             s_q;
	logic [62:0]             dv_num_q;
	logic [31:0]             dv_rem_q;
	logic [5:0]              dv_cnt_q;
	logic                    dv_busy_q, dv_neg_q;

	logic signed [DataW-1:0] opa, opb, addv;
	logic signed [63:0]      prod_c, rnd_c, add64, acc_sum, qv, sq, term, div_sum, wr_sum;
	logic signed [63:0]      prod_abs;
	logic [62:0]             dividend;
	logic signed [32:0]      s_c;
	logic [32:0]             trial;
	logic                    ge;
	logic                    wr_en, wr_sat;
	logic signed [DataW-1:0] wr_val;

	function automatic logic signed [DataW-1:0] pick(input opnd_t o);
		logic signed [DataW-1:0] v;
		case (o)
			OP_ZERO: v = '0;
			OP_ONE:  v = ONE_Q;
			OP_MONE: v = MONE_Q;
			OP_P:    v = x_q[0];
			OP_K1:   v = x_q[1];
			OP_K2:   v = x_q[2];
			OP_DX:   v = dx_q;
			OP_DT:   v = $signed({1'b0, dt_q});
			OP_MEAS: v = meas_q;
			OP_Q0:   v = $signed({1'b0, q0_q});
			OP_Q1:   v = $signed({1'b0, q1_q});
			OP_Q2:   v = $signed({1'b0, q2_q});
			OP_T:    v = t_q;
			OP_Y:    v = y_q;
			OP_F0:   v = f_q[0];
			OP_F1:   v = f_q[1];
			OP_F2:   v = f_q[2];
			OP_PF0:  v = pf_q[0];
			OP_PF1:  v = pf_q[1];
			OP_PF2:  v = pf_q[2];
			OP_C0:   v = c_q[0];
			OP_C1:   v = c_q[1];
			OP_C2:   v = c_q[2];
			OP_C3:   v = c_q[3];
			OP_C4:   v = c_q[4];
			OP_C5:   v = c_q[5];
			OP_C6:   v = c_q[6];
			OP_C7:   v = c_q[7];
			OP_C8:   v = c_q[8];
			OP_O0:   v = o_q[0];
			OP_O1:   v = o_q[1];
			OP_O2:   v = o_q[2];
			OP_O3:   v = o_q[3];
			OP_O6:   v = o_q[4];
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa      = pick(ctrl.cmd.a);
		opb      = pick(ctrl.cmd.b);
		addv     = pick(ctrl.cmd.add);
		prod_c   = opa * opb;
		rnd_c    = (prod_s1 + 64'sd32768) >>> 16;
		add64    = 64'(addv);
		acc_sum  = (ctrl.cmd.first ? add64 : acc_q) + rnd_c;
		qv       = $signed({1'b0, dv_num_q});
		sq       = dv_neg_q ? -qv : qv;
		term     = ctrl.cmd.neg ? -sq : sq;
		div_sum  = add64 + term;
		wr_sum   = ctrl.div_fin ? div_sum : acc_sum;
		wr_en    = ctrl.div_fin || (ctrl.acc_en && ctrl.cmd.last);
		if (wr_sum > 64'sd2147483647) begin
			wr_val = 32'sh7fffffff;
			wr_sat = 1'b1;
		end else if (wr_sum < -64'sd2147483648) begin
			wr_val = 32'sh80000000;
			wr_sat = 1'b1;
		end else begin
			wr_val = wr_sum[31:0];
			wr_sat = 1'b0;
		end
		prod_abs = prod_s1[63] ? -prod_s1 : prod_s1;
		dividend = prod_abs[62:0] + {32'd0, s_q[31:1]};
		s_c      = {c_q[0][31], c_q[0]} + $signed({2'b00, r_q});
		trial    = {dv_rem_q, dv_num_q[62]};
		ge       = (trial >= {1'b0, s_q});
	end

	assign stat.s_nonpos = s_c[32] || (s_c == 33'sd0);
	assign stat.div_busy = dv_busy_q;
	assign x0  = x_q[0];
	assign x1  = x_q[1];
	assign x2  = x_q[2];
	assign c0  = c_q[0];
	assign sat = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= MEAS_VAR_RST;
			q0_q  <= NOISE_RST;
			q1_q  <= NOISE_RST;
			q2_q  <= NOISE_RST;
			sat_q <= 1'b0;
			for (int i = 0; i < 3; i++) x_q[i] <= '0;
			for (int i = 0; i < 9; i++) c_q[i] <= (i % 4 == 0) ? ONE_Q : '0;
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MEAS_VAR: r_q  <= cfg_data;
					REG_NOISE_P:  q0_q <= cfg_data;
					REG_NOISE_K1: q1_q <= cfg_data;
					REG_NOISE_K2: q2_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (ctrl.clr_sat) begin
				sat_q <= 1'b0;
			end else if (ctrl.set_sat || (wr_en && wr_sat)) begin
				sat_q <= 1'b1;
			end
			if (wr_en) begin
				case (ctrl.cmd.dst)
					OP_P:  x_q[0] <= wr_val;
					OP_K1: x_q[1] <= wr_val;
					OP_K2: x_q[2] <= wr_val;
					OP_C0: c_q[0] <= wr_val;
					OP_C1: c_q[1] <= wr_val;
					OP_C2: c_q[2] <= wr_val;
					OP_C3: c_q[3] <= wr_val;
					OP_C4: c_q[4] <= wr_val;
					OP_C5: c_q[5] <= wr_val;
					OP_C6: c_q[6] <= wr_val;
					OP_C7: c_q[7] <= wr_val;
					OP_C8: c_q[8] <= wr_val;
					default: begin
					end
				endcase
			end
			if (ctrl.div_start) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q  <= 6'd63;
			end else if (dv_busy_q) begin
				dv_cnt_q <= dv_cnt_q - 6'd1;
				if (dv_cnt_q == 6'd1) begin
					dv_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			dx_q   <= displacement_step;
			dt_q   <= elapsed_time;
			meas_q <= measured_pressure;
		end
		if (ctrl.snap) begin
			s_q    <= s_c[31:0];
			o_q[0] <= c_q[0];
			o_q[1] <= c_q[1];
			o_q[2] <= c_q[2];
			o_q[3] <= c_q[3];
			o_q[4] <= c_q[6];
		end
		if (ctrl.mul_en) begin
			prod_s1 <= prod_c;
		end
		if (ctrl.acc_en) begin
			acc_q <= acc_sum;
		end
		if (wr_en) begin
			case (ctrl.cmd.dst)
				OP_T:   t_q     <= wr_val;
				OP_Y:   y_q     <= wr_val;
				OP_F0:  f_q[0]  <= wr_val;
				OP_F1:  f_q[1]  <= wr_val;
				OP_F2:  f_q[2]  <= wr_val;
				OP_PF0: pf_q[0] <= wr_val;
				OP_PF1: pf_q[1] <= wr_val;
				OP_PF2: pf_q[2] <= wr_val;
				default: begin
				end
			endcase
		end
		if (ctrl.div_start) begin
			dv_num_q <= dividend;
			dv_rem_q <= '0;
			dv_neg_q <= prod_s1[63];
		end else if (dv_busy_q) begin
			dv_rem_q <= ge ? 32'(trial - {1'b0, s_q}) : trial[31:0];
			dv_num_q <= {dv_num_q[61:0], ge};
		end
	end

endmodule

@@ hdl/pressure_elastic_ekf_unit.sv @@
// Top level of the three-state pressure elastic EKF unit.
//
//  channel | handshake          | payload
//  cfg     | cfg_we             | cfg_index, cfg_data
//  in      | in_valid, in_ready | func, measured_pressure, elapsed_time, displacement_step
//  out     | out_valid, out_ready | estimates, pressure_variance, saturated
//
// A predict beat takes 28 microcode products, each a multiply state and an accumulate state.
// An update beat takes 12 quotient steps (multiply, start, 63 divider iterations,
// write-back) after the innovation product.
// Reset clears state to zero, covariance to identity, registers to their defaults.
// A finished result waits in the output register; the next beat is taken meanwhile.
module pressure_elastic_ekf_unit import pekf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IdxW-1:0]         cfg_index,
	input  logic [CfgW-1:0]         cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic signed [DataW-1:0] measured_pressure,
	input  logic [CfgW-1:0]         elapsed_time,
	input  logic signed [DataW-1:0] displacement_step,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DataW-1:0] pressure_estimate,
	output logic signed [DataW-1:0] linear_coefficient,
	output logic signed [DataW-1:0] pressure_coefficient,
	output logic signed [DataW-1:0] pressure_variance,
	output logic                    saturated
);

	dp_ctrl_t                ctrl;
	dp_stat_t                stat;
	logic                    load_out;
	logic                    out_valid_q;
	logic signed [DataW-1:0] x0, x1, x2, c0;
	logic                    sat;
	logic signed [DataW-1:0] pe_q, lc_q, pc_q, pv_q;
	logic                    sat_q;

	pekf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.out_busy (out_valid_q && !out_ready),
		.stat     (stat),
		.in_ready (in_ready),
		.load_out (load_out),
		.ctrl     (ctrl)
	);

	pekf_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.measured_pressure (measured_pressure),
		.elapsed_time      (elapsed_time),
		.displacement_step (displacement_step),
		.stat              (stat),
		.x0                (x0),
		.x1                (x1),
		.x2                (x2),
		.c0                (c0),
		.sat               (sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pe_q  <= x0;
			lc_q  <= x1;
			pc_q  <= x2;
			pv_q  <= c0;
			sat_q <= sat;
		end
	end

	assign out_valid            = out_valid_q;
	assign pressure_estimate    = pe_q;
	assign linear_coefficient   = lc_q;
	assign pressure_coefficient = pc_q;
	assign pressure_variance    = pv_q;
	assign saturated            = sat_q;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the pressure elastic EKF unit: random and directed beats.
`timescale 1ns / 1ps

module testbench;
	import pekf_pkg::*;

	typedef struct {
		logic                    func;
		logic signed [DataW-1:0] meas;
		logic [CfgW-1:0]         dt;
		logic signed [DataW-1:0] dx;
	} ekf_beat_t;

	typedef struct {
		logic signed [DataW-1:0] pres;
		logic signed [DataW-1:0] k1;
		logic signed [DataW-1:0] k2;
		logic signed [DataW-1:0] pvar;
		logic                    sat;
	} ekf_est_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = FUNC_PREDICT;
	logic signed [DataW-1:0] measured_pressure = '0;
	logic [CfgW-1:0] elapsed_time = '0;
	logic signed [DataW-1:0] displacement_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DataW-1:0] pressure_estimate, linear_coefficient;
	logic signed [DataW-1:0] pressure_coefficient, pressure_variance;
	logic saturated;

	pressure_elastic_ekf_unit dut (.*);

	always #5 clk = ~clk;

	ekf_beat_t pend_beats[$];
	ekf_est_t  est_queue[$];
	longint    filt_x[3];
	longint    filt_c[9];
	longint    reg_r, reg_q0, reg_q1, reg_q2;
	bit        clip_hit;
	bit        in_fired, out_fired;
	int        in_gap, out_wait, hold_left, beats_out, errors, cyc;
	bit        hold_done;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			clip_hit = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clip_hit = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + 32768) >>> 16;
	endfunction

	function automatic longint qdiv(longint num, longint den);
		longint unsigned d, mag, q;
		d = den;
		mag = (num < 0) ? -num : num;
		q = (mag + d / 2) / d;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic ekf_est_t ekf_step(ekf_beat_t b);
		longint c[9], f[3], pf[3];
		longint p, rate, s, y, dt, dx;
		ekf_est_t e;
		clip_hit = 0;
		c = filt_c;
		if (b.func == FUNC_PREDICT) begin
			dt = longint'(b.dt);
			dx = longint'(b.dx);
			p = filt_x[0];
			rate = clip32(filt_x[1] + qmul(p, filt_x[2]));
			filt_x[0] = clip32(p + qmul(rate, dx));
			f[0] = clip32(65536 + qmul(filt_x[2], dx));
			f[1] = dx;
			f[2] = clip32(qmul(p, dx));
			for (int i = 0; i < 3; i++)
				pf[i] = clip32(qmul(c[3*i], f[0]) + qmul(c[3*i+1], f[1]) + qmul(c[3*i+2], f[2]));
			filt_c[0] = clip32(qmul(f[0], pf[0]) + qmul(f[1], pf[1]) + qmul(f[2], pf[2])
				+ qmul(reg_q0, dt));
			filt_c[1] = clip32(qmul(f[0], c[1]) + qmul(f[1], c[4]) + qmul(f[2], c[7]));
			filt_c[2] = clip32(qmul(f[0], c[2]) + qmul(f[1], c[5]) + qmul(f[2], c[8]));
			filt_c[3] = pf[1];
			filt_c[4] = clip32(c[4] + qmul(reg_q1, dt));
			filt_c[6] = pf[2];
			filt_c[8] = clip32(c[8] + qmul(reg_q2, dt));
		end else begin
			s = c[0] + reg_r;
			if (s <= 0) begin
				clip_hit = 1;
			end else begin
				y = clip32(longint'(b.meas) - filt_x[0]);
				for (int i = 0; i < 3; i++)
					filt_x[i] = clip32(filt_x[i] + qdiv(c[3*i] * y, s));
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						filt_c[3*i+j] = clip32(c[3*i+j] - qdiv(c[3*i] * c[j], s));
			end
		end
		e.pres = filt_x[0][31:0];
		e.k1 = filt_x[1][31:0];
		e.k2 = filt_x[2][31:0];
		e.pvar = filt_c[0][31:0];
		e.sat = clip_hit;
		return e;
	endfunction

	function automatic ekf_beat_t mk_beat(logic fn, logic signed [31:0] m,
			logic [30:0] t, logic signed [31:0] x);
		ekf_beat_t b;
		b.func = fn; b.meas = m; b.dt = t; b.dx = x;
		return b;
	endfunction

	function automatic ekf_beat_t rand_beat();
		ekf_beat_t b;
		if ($urandom_range(0, 9) == 0) begin
			b.func = 1'($urandom_range(0, 1));
			b.meas = $urandom;
			b.dt = 31'($urandom);
			b.dx = $urandom;
		end else begin
			b.func = ($urandom_range(0, 99) < 35) ? FUNC_UPDATE : FUNC_PREDICT;
			b.meas = $signed($urandom_range(0, 2097152)) - 1048576;
			b.dt = 31'($urandom_range(0, 262144));
			b.dx = $signed($urandom_range(0, 131072)) - 65536;
		end
		return b;
	endfunction

	task automatic reg_write(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MEAS_VAR: reg_r = val;
			REG_NOISE_P:  reg_q0 = val;
			REG_NOISE_K1: reg_q1 = val;
			REG_NOISE_K2: reg_q2 = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pend_beats.size() == 0 && !in_valid && est_queue.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			pend_beats.push_back(rand_beat());
	endtask

	always @(posedge clk) begin
		cyc++;
		if (cyc > 6000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		in_fired = in_valid && in_ready;
		if (in_fired)
			est_queue.push_back(ekf_step(mk_beat(func, measured_pressure, elapsed_time,
				displacement_step)));
	end

	always @(negedge clk) begin
		ekf_beat_t b;
		if (arst_n && (!in_valid || in_fired)) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (pend_beats.size() > 0) begin
				b = pend_beats.pop_front();
				func <= b.func;
				measured_pressure <= b.meas;
				elapsed_time <= b.dt;
				displacement_step <= b.dx;
				in_valid <= 1'b1;
				in_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		ekf_est_t e;
		out_fired = out_valid && out_ready;
		if (out_fired) begin
			beats_out++;
			if (est_queue.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = est_queue.pop_front();
				if (pressure_estimate !== e.pres) begin
					$error("pressure_estimate exp %h got %h", e.pres, pressure_estimate);
					errors++;
				end
				if (linear_coefficient !== e.k1) begin
					$error("linear_coefficient exp %h got %h", e.k1, linear_coefficient);
					errors++;
				end
				if (pressure_coefficient !== e.k2) begin
					$error("pressure_coefficient exp %h got %h", e.k2, pressure_coefficient);
					errors++;
				end
				if (pressure_variance !== e.pvar) begin
					$error("pressure_variance exp %h got %h", e.pvar, pressure_variance);
					errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, saturated);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && beats_out >= 300) begin
				hold_done = 1;
				hold_left = 5000;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (out_fired || !out_ready) begin
				if (out_fired)
					out_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
				if (out_wait > 0) begin
					out_ready <= 1'b0;
					out_wait--;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		reg_r = 65536; reg_q0 = 655; reg_q1 = 655; reg_q2 = 655;
		filt_x = '{0, 0, 0};
		filt_c = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		pend_beats.push_back(mk_beat(FUNC_PREDICT, 32'sh7fffffff, 31'd0, 32'sd0));
		pend_beats.push_back(mk_beat(FUNC_UPDATE, 32'sd65536, 31'h7fffffff, 32'sh7fffffff));
		pend_beats.push_back(mk_beat(FUNC_PREDICT, 32'sd0, 31'd65536, 32'sd65536));
		pend_beats.push_back(mk_beat(FUNC_UPDATE, 32'sh7fffffff, 31'd0, 32'sd0));
		pend_beats.push_back(mk_beat(FUNC_PREDICT, 32'sd0, 31'h7fffffff, 32'sh7fffffff));
		pend_beats.push_back(mk_beat(FUNC_UPDATE, 32'sh80000000, 31'd0, 32'sd0));
		pend_beats.push_back(mk_beat(FUNC_PREDICT, 32'sd0, 31'h7fffffff, 32'sh80000000));
		pend_beats.push_back(mk_beat(FUNC_UPDATE, 32'sd0, 31'd0, 32'sd0));
		add_random(330);
		drain();

		reg_write(REG_MEAS_VAR, 31'd0);
		reg_write(REG_NOISE_P, 31'd0);
		reg_write(REG_NOISE_K1, 31'd0);
		reg_write(REG_NOISE_K2, 31'd0);
		reg_write(3'd5, 31'h7fffffff);
		pend_beats.push_back(mk_beat(FUNC_UPDATE, 32'sd131072, 31'd0, 32'sd0));
		pend_beats.push_back(mk_beat(FUNC_UPDATE, 32'sd65536, 31'd0, 32'sd0));
		pend_beats.push_back(mk_beat(FUNC_UPDATE, -32'sd65536, 31'd0, 32'sd0));
		pend_beats.push_back(mk_beat(FUNC_PREDICT, 32'sd0, 31'd65536, 32'sd32768));
		add_random(320);
		drain();

		reg_write(REG_MEAS_VAR, 31'h7fffffff);
		reg_write(REG_NOISE_P, 31'h7fffffff);
		reg_write(REG_NOISE_K1, 31'h7fffffff);
		reg_write(REG_NOISE_K2, 31'h7fffffff);
		add_random(330);
		drain();

		reg_write(REG_MEAS_VAR, 31'($urandom));
		reg_write(REG_NOISE_P, 31'($urandom));
		reg_write(REG_NOISE_K1, 31'($urandom));
		reg_write(REG_NOISE_K2, 31'($urandom));
		add_random(330);
		drain();

		reg_write(REG_MEAS_VAR, 31'd1);
		reg_write(REG_NOISE_P, 31'($urandom_range(0, 4096)));
		reg_write(REG_NOISE_K1, 31'($urandom_range(0, 4096)));
		reg_write(REG_NOISE_K2, 31'($urandom_range(0, 4096)));
		add_random(330);
		drain();

		repeat (1000) @(negedge clk);
		if (errors == 0 && est_queue.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/pekf_pkg.sv
hdl/pekf_ctrl.sv
hdl/pekf_dpath.sv
hdl/pressure_elastic_ekf_unit.sv
tb/testbench.sv
